[rtl/pcfc_pkg.sv]
// ----------------------------------------------------------------------------
// pcfc_pkg
// shared widths, register indexes, phase codes and interface types for the
// parallel camera frame capture block
// ----------------------------------------------------------------------------
package pcfc_pkg;

   // configuration field widths
   localparam int LINE_PIXELS_W = 10;
   localparam int FRAME_LINES_W = 9;
   localparam int PIXEL_BYTES_W = 2;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 16;

   // result field widths
   localparam int BYTE_W       = 8;
   localparam int BYTE_INDEX_W = 11;
   localparam int LINE_INDEX_W = 9;

   // line length in bytes: up to 1023 pixels times two bytes
   localparam int LINE_LEN_W = 12;

   // parameter defaults
   localparam int MAX_LINE_PIXELS_DEF = 640;
   localparam int MAX_FRAME_LINES_DEF = 480;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_PIXELS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_LINES = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_BYTES = 8'd2;

   // register reset values
   localparam logic [LINE_PIXELS_W-1:0] LINE_PIXELS_RST = 10'd160;
   localparam logic [FRAME_LINES_W-1:0] FRAME_LINES_RST = 9'd120;
   localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = 2'd2;

   // capture phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_VSYNC = 2'd1;
   localparam logic [1:0] PH_PLOW  = 2'd2;
   localparam logic [1:0] PH_PHIGH = 2'd3;

   // effective (saturated) frame geometry
   typedef struct packed {
      logic [LINE_LEN_W-1:0]    line_len;
      logic [FRAME_LINES_W-1:0] lines;
   } cfg_type;

   // one pin sample
   typedef struct packed {
      logic              start_req;
      logic              vsync;
      logic              pclk;
      logic [BYTE_W-1:0] bus_byte;
   } sample_type;

   // one captured byte
   typedef struct packed {
      logic                    hit;
      logic [BYTE_W-1:0]       byte_value;
      logic [BYTE_INDEX_W-1:0] byte_index;
      logic [LINE_INDEX_W-1:0] line_index;
      logic                    line_end;
      logic                    frame_end;
   } result_type;

endpackage

[rtl/parallel_camera_frame_capture.sv]
// ----------------------------------------------------------------------------
// parallel_camera_frame_capture
// captures one frame of bytes from sampled parallel camera pins
// ----------------------------------------------------------------------------
// throughput: one request per cycle by the phase/counter update unless rsp stalls
// a waiting result does not block the input register while the result slot is free
// reset: synchronous, active high; clears valids, phase and counters, loads
// register defaults (160 pixels, 120 lines, 2 bytes per pixel)
// ----------------------------------------------------------------------------
module parallel_camera_frame_capture #(
   parameter int MAX_LINE_PIXELS = pcfc_pkg::MAX_LINE_PIXELS_DEF,
   parameter int MAX_FRAME_LINES = pcfc_pkg::MAX_FRAME_LINES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   // pin sample requests
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   input  logic                                req_vsync,
   input  logic                                req_pclk,
   input  logic [pcfc_pkg::BYTE_W-1:0]         req_bus_byte,

   // captured bytes
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcfc_pkg::BYTE_W-1:0]         rsp_byte_value,
   output logic [pcfc_pkg::BYTE_INDEX_W-1:0]   rsp_byte_index,
   output logic [pcfc_pkg::LINE_INDEX_W-1:0]   rsp_line_index,
   output logic                                rsp_line_end,
   output logic                                rsp_frame_end,

   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pcfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pcfc_pkg::CSR_DATA_W-1:0]     csr_data
);

   // input register
   logic                   in_valid_ff;
   pcfc_pkg::sample_type   sample_ff;

   // result register
   logic                   rsp_valid_ff;
   pcfc_pkg::result_type   rsp_ff;

   pcfc_pkg::cfg_type      cfg;
   pcfc_pkg::result_type   result;
   logic                   advance;

   // registers are always writable
   assign csr_ready = 1'b1;

   pcfc_csr #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
      .MAX_FRAME_LINES (MAX_FRAME_LINES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // the held sample moves on when the result slot is free or being emptied
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // sample payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff.start_req <= req_start_req;
         sample_ff.vsync     <= req_vsync;
         sample_ff.pclk      <= req_pclk;
         sample_ff.bus_byte  <= req_bus_byte;
      end
   end

   pcfc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (sample_ff),
      .cfg    (cfg),
      .result (result)
   );

   // result slot: filled by a captured byte, emptied by the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.hit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.hit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_value = rsp_ff.byte_value;
   assign rsp_byte_index = rsp_ff.byte_index;
   assign rsp_line_index = rsp_ff.line_index;
   assign rsp_line_end   = rsp_ff.line_end;
   assign rsp_frame_end  = rsp_ff.frame_end;

endmodule

[rtl/pcfc_csr.sv]
// ----------------------------------------------------------------------------
// pcfc_csr
// configuration registers with saturation to the supported frame geometry
// ----------------------------------------------------------------------------
module pcfc_csr #(
   parameter int MAX_LINE_PIXELS = pcfc_pkg::MAX_LINE_PIXELS_DEF,
   parameter int MAX_FRAME_LINES = pcfc_pkg::MAX_FRAME_LINES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [pcfc_pkg::CSR_INDEX_W-1:0]  wr_index,
   input  logic [pcfc_pkg::CSR_DATA_W-1:0]   wr_data,
   output pcfc_pkg::cfg_type                 cfg
);

   logic [pcfc_pkg::LINE_PIXELS_W-1:0] line_pixels_ff;
   logic [pcfc_pkg::FRAME_LINES_W-1:0] frame_lines_ff;
   logic [pcfc_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_ff;

   logic [pcfc_pkg::LINE_LEN_W-1:0]    px_wide;
   logic [pcfc_pkg::LINE_LEN_W-1:0]    px_sat;
   logic [pcfc_pkg::FRAME_LINES_W+1:0] ln_wide;
   logic [pcfc_pkg::FRAME_LINES_W+1:0] ln_sat;
   logic                               two_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff <= pcfc_pkg::LINE_PIXELS_RST;
         frame_lines_ff <= pcfc_pkg::FRAME_LINES_RST;
         pixel_bytes_ff <= pcfc_pkg::PIXEL_BYTES_RST;
      end else if (wr_en) begin
         case (wr_index)
            pcfc_pkg::REG_LINE_PIXELS: begin
               line_pixels_ff <= wr_data[pcfc_pkg::LINE_PIXELS_W-1:0];
            end
            pcfc_pkg::REG_FRAME_LINES: begin
               frame_lines_ff <= wr_data[pcfc_pkg::FRAME_LINES_W-1:0];
            end
            pcfc_pkg::REG_PIXEL_BYTES: begin
               pixel_bytes_ff <= wr_data[pcfc_pkg::PIXEL_BYTES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // saturate to 1..max, 0 and 1 bytes per pixel act as one, 2 and 3 as two
   always_comb begin
      px_wide = pcfc_pkg::LINE_LEN_W'(line_pixels_ff);
      if (px_wide == '0) begin
         px_sat = pcfc_pkg::LINE_LEN_W'(1);
      end else if (px_wide > pcfc_pkg::LINE_LEN_W'(MAX_LINE_PIXELS)) begin
         px_sat = pcfc_pkg::LINE_LEN_W'(MAX_LINE_PIXELS);
      end else begin
         px_sat = px_wide;
      end

      ln_wide = (pcfc_pkg::FRAME_LINES_W+2)'(frame_lines_ff);
      if (ln_wide == '0) begin
         ln_sat = (pcfc_pkg::FRAME_LINES_W+2)'(1);
      end else if (ln_wide > (pcfc_pkg::FRAME_LINES_W+2)'(MAX_FRAME_LINES)) begin
         ln_sat = (pcfc_pkg::FRAME_LINES_W+2)'(MAX_FRAME_LINES);
      end else begin
         ln_sat = ln_wide;
      end

      two_bytes    = pixel_bytes_ff[1];
      cfg.line_len = two_bytes ? {px_sat[pcfc_pkg::LINE_LEN_W-2:0], 1'b0} : px_sat;
      cfg.lines    = ln_sat[pcfc_pkg::FRAME_LINES_W-1:0];
   end

endmodule

[rtl/pcfc_core.sv]
// ----------------------------------------------------------------------------
// pcfc_core
// capture phase sequencer and byte / line counters, one sample per step
// ----------------------------------------------------------------------------
module pcfc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  pcfc_pkg::sample_type   sample,
   input  pcfc_pkg::cfg_type      cfg,
   output pcfc_pkg::result_type   result
);

   logic [1:0]                            phase_ff, phase_in;
   logic [pcfc_pkg::BYTE_INDEX_W-1:0]     byte_count_ff, byte_count_in;
   logic [pcfc_pkg::LINE_INDEX_W-1:0]     line_count_ff, line_count_in;

   logic [pcfc_pkg::LINE_LEN_W-1:0]       byte_next;
   logic [pcfc_pkg::FRAME_LINES_W:0]      line_next;
   logic                                  lend;
   logic                                  fend;

   always_comb begin
      byte_next = pcfc_pkg::LINE_LEN_W'(byte_count_ff) + pcfc_pkg::LINE_LEN_W'(1);
      line_next = (pcfc_pkg::FRAME_LINES_W+1)'(line_count_ff)
                + (pcfc_pkg::FRAME_LINES_W+1)'(1);
      lend      = byte_next >= cfg.line_len;
      fend      = lend && (line_next >= (pcfc_pkg::FRAME_LINES_W+1)'(cfg.lines));

      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      line_count_in = line_count_ff;

      result.hit        = 1'b0;
      result.byte_value = sample.bus_byte;
      result.byte_index = byte_count_ff;
      result.line_index = line_count_ff;
      result.line_end   = lend;
      result.frame_end  = fend;

      case (phase_ff)
         pcfc_pkg::PH_IDLE: begin
            // arming sample only arms
            if (sample.start_req) begin
               phase_in      = pcfc_pkg::PH_VSYNC;
               byte_count_in = '0;
               line_count_in = '0;
            end
         end
         pcfc_pkg::PH_VSYNC: begin
            if (!sample.vsync) begin
               phase_in = pcfc_pkg::PH_PLOW;
            end
         end
         pcfc_pkg::PH_PHIGH: begin
            if (sample.pclk) begin
               phase_in = pcfc_pkg::PH_PLOW;
            end
         end
         default: begin
            // waiting for pclk low: take a byte
            if (!sample.pclk) begin
               result.hit = 1'b1;
               if (fend) begin
                  phase_in      = pcfc_pkg::PH_IDLE;
                  byte_count_in = '0;
                  line_count_in = '0;
               end else begin
                  phase_in = pcfc_pkg::PH_PHIGH;
                  if (lend) begin
                     byte_count_in = '0;
                     line_count_in = line_next[pcfc_pkg::LINE_INDEX_W-1:0];
                  end else begin
                     byte_count_in = byte_next[pcfc_pkg::BYTE_INDEX_W-1:0];
                  end
               end
            end
         end
      endcase

      if (!step) begin
         result.hit = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pcfc_pkg::PH_IDLE;
         byte_count_ff <= '0;
         line_count_ff <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         line_count_ff <= line_count_in;
      end
   end

endmodule

[rtl/pcfc_checker.sv]
// ----------------------------------------------------------------------------
// pcfc_checker
// port-level checks for the frame capture block, bound to the top level
// ----------------------------------------------------------------------------
module pcfc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [pcfc_pkg::BYTE_W-1:0]         rsp_byte_value,
   input logic [pcfc_pkg::BYTE_INDEX_W-1:0]   rsp_byte_index,
   input logic [pcfc_pkg::LINE_INDEX_W-1:0]   rsp_line_index,
   input logic                                rsp_line_end,
   input logic                                rsp_frame_end
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_value)
         && $stable(rsp_byte_index) && $stable(rsp_line_index)
         && $stable(rsp_line_end) && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   // frame end is always also a line end
   a_frame_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_line_end)
      else $error("frame end without line end");

   // reset empties the result slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result slot never blocks requests
   a_skid: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty result slot");

endmodule

bind parallel_camera_frame_capture pcfc_checker u_pcfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_byte_value (rsp_byte_value),
   .rsp_byte_index (rsp_byte_index),
   .rsp_line_index (rsp_line_index),
   .rsp_line_end   (rsp_line_end),
   .rsp_frame_end  (rsp_frame_end)
);

[bench/capture_check_pkg.sv]
// ----------------------------------------------------------------------------
// capture_check_pkg
// predictor and scoreboard for the parallel camera frame capture bench:
// tracks phase, counters and geometry, and queues the bytes it expects
// ----------------------------------------------------------------------------
package capture_check_pkg;

   class capture_scoreboard;
      logic [pcfc_pkg::LINE_PIXELS_W-1:0] line_pixels;
      logic [pcfc_pkg::FRAME_LINES_W-1:0] frame_lines;
      logic [pcfc_pkg::PIXEL_BYTES_W-1:0] pixel_bytes;
      logic [1:0]                         phase;
      logic [pcfc_pkg::BYTE_INDEX_W-1:0]  byte_count;
      logic [pcfc_pkg::LINE_INDEX_W-1:0]  line_count;
      pcfc_pkg::result_type               pending_bytes[$];
      int                                 errors;

      function new();
         line_pixels = pcfc_pkg::LINE_PIXELS_RST;
         frame_lines = pcfc_pkg::FRAME_LINES_RST;
         pixel_bytes = pcfc_pkg::PIXEL_BYTES_RST;
         phase       = pcfc_pkg::PH_IDLE;
         byte_count  = '0;
         line_count  = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [pcfc_pkg::CSR_INDEX_W-1:0] index,
                              logic [pcfc_pkg::CSR_DATA_W-1:0] data);
         case (index)
            pcfc_pkg::REG_LINE_PIXELS: line_pixels = data[pcfc_pkg::LINE_PIXELS_W-1:0];
            pcfc_pkg::REG_FRAME_LINES: frame_lines = data[pcfc_pkg::FRAME_LINES_W-1:0];
            pcfc_pkg::REG_PIXEL_BYTES: pixel_bytes = data[pcfc_pkg::PIXEL_BYTES_W-1:0];
            default: ;
         endcase
      endfunction

      // returns 1 when the sample moved the phase or captured a byte
      function bit note_sample(pcfc_pkg::sample_type s);
         int unsigned          px;
         int unsigned          lines;
         int unsigned          bpp;
         int unsigned          line_len;
         bit                   lend;
         bit                   fend;
         pcfc_pkg::result_type r;
         if (phase == pcfc_pkg::PH_IDLE) begin
            if (!s.start_req) return 1'b0;
            phase      = pcfc_pkg::PH_VSYNC;
            byte_count = '0;
            line_count = '0;
            return 1'b1;
         end
         if (phase == pcfc_pkg::PH_VSYNC) begin
            if (s.vsync) return 1'b0;
            phase = pcfc_pkg::PH_PLOW;
            return 1'b1;
         end
         if (phase == pcfc_pkg::PH_PHIGH) begin
            if (!s.pclk) return 1'b0;
            phase = pcfc_pkg::PH_PLOW;
            return 1'b1;
         end
         if (s.pclk) return 1'b0;

         // saturated geometry
         px = 32'(line_pixels);
         if (px < 1) px = 1;
         if (px > pcfc_pkg::MAX_LINE_PIXELS_DEF) px = pcfc_pkg::MAX_LINE_PIXELS_DEF;
         lines = 32'(frame_lines);
         if (lines < 1) lines = 1;
         if (lines > pcfc_pkg::MAX_FRAME_LINES_DEF) lines = pcfc_pkg::MAX_FRAME_LINES_DEF;
         bpp = 32'(pixel_bytes);
         if (bpp < 1) bpp = 1;
         if (bpp > 2) bpp = 2;
         line_len = px * bpp;

         lend = (32'(byte_count) + 32'd1) >= line_len;
         fend = lend && ((32'(line_count) + 32'd1) >= lines);

         r.hit        = 1'b1;
         r.byte_value = s.bus_byte;
         r.byte_index = byte_count;
         r.line_index = line_count;
         r.line_end   = lend;
         r.frame_end  = fend;
         pending_bytes.push_back(r);

         if (fend) begin
            phase      = pcfc_pkg::PH_IDLE;
            byte_count = '0;
            line_count = '0;
         end else begin
            phase = pcfc_pkg::PH_PHIGH;
            if (lend) begin
               byte_count = '0;
               line_count = line_count + 1'b1;
            end else begin
               byte_count = byte_count + 1'b1;
            end
         end
         return 1'b1;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_byte(pcfc_pkg::result_type got);
         pcfc_pkg::result_type want;
         if (pending_bytes.size() == 0) begin
            $error("captured byte %0d at line %0d with none expected",
                   got.byte_value, got.line_index);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         compare_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
         compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
         compare_field("line_index", 16'(want.line_index), 16'(got.line_index));
         compare_field("line_end", 16'(want.line_end), 16'(got.line_end));
         compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
      endfunction
   endclass

endpackage

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives sampled camera pins into the frame capture block, predicts every
// captured byte with its position and end flags, and checks the byte stream
// under random idling on both sides and several frame geometries
// ----------------------------------------------------------------------------
module testbench;

   localparam int TOTAL_ITEMS   = 1200;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // pin sample requests
   logic                        req_valid     = 1'b0;
   logic                        req_ready;
   logic                        req_start_req = 1'b0;
   logic                        req_vsync     = 1'b0;
   logic                        req_pclk      = 1'b0;
   logic [pcfc_pkg::BYTE_W-1:0] req_bus_byte  = '0;

   // captured bytes
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [pcfc_pkg::BYTE_W-1:0]       rsp_byte_value;
   logic [pcfc_pkg::BYTE_INDEX_W-1:0] rsp_byte_index;
   logic [pcfc_pkg::LINE_INDEX_W-1:0] rsp_line_index;
   logic                              rsp_line_end;
   logic                              rsp_frame_end;

   // configuration writes
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [pcfc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pcfc_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   capture_check_pkg::capture_scoreboard sb;
   bit                                   idle_on      = 1'b1;
   int                                   sent_samples = 0;
   int                                   cycle_count  = 0;

   parallel_camera_frame_capture i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_req  (req_start_req),
      .req_vsync      (req_vsync),
      .req_pclk       (req_pclk),
      .req_bus_byte   (req_bus_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index),
      .rsp_line_index (rsp_line_index),
      .rsp_line_end   (rsp_line_end),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   // watchdog: a hung handshake or a lost byte ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side stalls about a quarter of the time unless idling is off
   always @(posedge clock) begin
      rsp_ready <= !idle_on || ($urandom_range(99) >= 24);
   end

   // every accepted byte is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_byte({1'b1, rsp_byte_value, rsp_byte_index, rsp_line_index,
                        rsp_line_end, rsp_frame_end});
   end

   function automatic logic random_bit();
      return $urandom_range(1) != 0;
   endfunction

   function automatic logic [pcfc_pkg::BYTE_W-1:0] random_byte();
      return pcfc_pkg::BYTE_W'($urandom_range(255));
   endfunction

   // one pin sample request, with a random gap ahead of it
   task automatic send_sample(logic start, logic vs, logic pc,
                              logic [pcfc_pkg::BYTE_W-1:0] data);
      while (idle_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      req_vsync     <= vs;
      req_pclk      <= pc;
      req_bus_byte  <= data;
      do @(posedge clock); while (!req_ready);
      void'(sb.note_sample({start, vs, pc, data}));
      sent_samples++;
   endtask

   // fully random pins
   task automatic random_samples(int count);
      repeat (count)
         send_sample(random_bit(), random_bit(), random_bit(), random_byte());
   endtask

   // stop requests, let the last bytes out, then give the block time to settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [pcfc_pkg::CSR_INDEX_W-1:0] index,
                            logic [pcfc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, data);
   endtask

   // all three registers with random upper bits, sometimes a write to no register
   task automatic write_geometry(logic [pcfc_pkg::LINE_PIXELS_W-1:0] px,
                                 logic [pcfc_pkg::FRAME_LINES_W-1:0] lines,
                                 logic [pcfc_pkg::PIXEL_BYTES_W-1:0] bpp);
      logic [pcfc_pkg::CSR_DATA_W-1:0] v_px;
      logic [pcfc_pkg::CSR_DATA_W-1:0] v_lines;
      logic [pcfc_pkg::CSR_DATA_W-1:0] v_bpp;
      v_px    = pcfc_pkg::CSR_DATA_W'($urandom);
      v_lines = pcfc_pkg::CSR_DATA_W'($urandom);
      v_bpp   = pcfc_pkg::CSR_DATA_W'($urandom);
      v_px[pcfc_pkg::LINE_PIXELS_W-1:0]    = px;
      v_lines[pcfc_pkg::FRAME_LINES_W-1:0] = lines;
      v_bpp[pcfc_pkg::PIXEL_BYTES_W-1:0]   = bpp;
      write_reg(pcfc_pkg::REG_LINE_PIXELS, v_px);
      write_reg(pcfc_pkg::REG_FRAME_LINES, v_lines);
      write_reg(pcfc_pkg::REG_PIXEL_BYTES, v_bpp);
      if ($urandom_range(99) < 30)
         write_reg(pcfc_pkg::CSR_INDEX_W'($urandom_range(3, 255)),
                   pcfc_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // well-formed capture steered by the predicted phase; pins are mostly
   // what the phase waits for, with held levels and stray starts mixed in
   task automatic capture_frame();
      if (sb.phase == pcfc_pkg::PH_IDLE)
         send_sample(1'b1, random_bit(), random_bit(), random_byte());
      while (sb.phase != pcfc_pkg::PH_IDLE) begin
         case (sb.phase)
            pcfc_pkg::PH_VSYNC: send_sample(random_bit(), $urandom_range(99) < 40,
                                            random_bit(), random_byte());
            pcfc_pkg::PH_PLOW: send_sample(random_bit(), random_bit(),
                                           $urandom_range(99) < 15, random_byte());
            default: send_sample(random_bit(), random_bit(),
                                 $urandom_range(99) >= 15, random_byte());
         endcase
      end
   endtask

   // start and then random pins, leaving a frame part way through
   task automatic broken_frame();
      if (sb.phase == pcfc_pkg::PH_IDLE)
         send_sample(1'b1, random_bit(), random_bit(), random_byte());
      random_samples($urandom_range(2, 10));
   endtask

   initial begin
      int phase_no;
      int pick;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: default geometry, arming and vsync samples, held pclk
      send_sample(1'b0, 1'b0, 1'b0, 8'hAA);   // idle without start: nothing
      send_sample(1'b1, 1'b0, 1'b0, 8'h55);   // arming sample only arms
      send_sample(1'b0, 1'b1, 1'b0, 8'h01);   // vsync still high
      send_sample(1'b0, 1'b0, 1'b0, 8'h02);   // vsync low sample only moves on
      send_sample(1'b0, 1'b1, 1'b0, 8'hFF);   // first byte, vsync no longer looked at
      send_sample(1'b1, 1'b0, 1'b0, 8'h11);   // pclk held low, start while busy
      send_sample(1'b0, 1'b0, 1'b1, 8'h22);   // pclk high again
      send_sample(1'b0, 1'b0, 1'b1, 8'h33);   // still high: nothing
      send_sample(1'b0, 1'b0, 1'b0, 8'h00);   // second byte
      send_sample(1'b0, 1'b1, 1'b1, 8'h44);
      drain();

      // shrink mid-frame with zero lengths: next byte is past both ends
      write_geometry(10'd0, 9'd0, 2'd0);
      send_sample(1'b0, 1'b0, 1'b0, 8'h5A);
      send_sample(1'b0, 1'b0, 1'b0, 8'hA5);   // back to idle: ignored
      drain();

      // two lines of two one-byte pixels
      write_geometry(10'd2, 9'd2, 2'd1);
      send_sample(1'b1, 1'b1, 1'b1, 8'h0F);
      send_sample(1'b0, 1'b0, 1'b1, 8'hF0);
      repeat (4) begin
         send_sample(1'b0, 1'b0, 1'b0, random_byte());
         send_sample(1'b0, 1'b1, 1'b1, random_byte());
      end
      drain();

      // two lines of two-byte pixels at full speed
      idle_on = 1'b0;
      write_geometry(10'd16, 9'd2, 2'd2);
      capture_frame();
      drain();

      // tall frame of single bytes
      idle_on = 1'b1;
      write_geometry(10'd1, 9'd24, 2'd1);
      capture_frame();
      drain();

      // over-range values saturate; leave the frame open for the next setting
      write_geometry(10'h3FF, 9'h1FF, 2'd3);
      broken_frame();
      random_samples(30);

      // random part: small geometries, mostly well-formed frames
      phase_no = 0;
      while (sent_samples < TOTAL_ITEMS) begin
         drain();
         idle_on = (phase_no % 6 != 3);
         write_geometry(pcfc_pkg::LINE_PIXELS_W'(($urandom_range(99) < 15) ? 0 :
                                                 $urandom_range(1, 4)),
                        pcfc_pkg::FRAME_LINES_W'(($urandom_range(99) < 15) ? 0 :
                                                 $urandom_range(1, 3)),
                        pcfc_pkg::PIXEL_BYTES_W'($urandom_range(3)));
         repeat ($urandom_range(1, 3)) begin
            pick = $urandom_range(99);
            if (pick < 70) capture_frame();
            else if (pick < 85) random_samples($urandom_range(1, 8));
            else broken_frame();
         end
         phase_no++;
      end
      drain();

      if (sb.errors == 0 && sb.pending_bytes.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/pcfc_pkg.sv
rtl/pcfc_csr.sv
rtl/pcfc_core.sv
rtl/parallel_camera_frame_capture.sv
rtl/pcfc_checker.sv
bench/capture_check_pkg.sv
bench/testbench.sv
